// ----- src/sbcr_pkg.sv -----
// ---------------------------------------------------------------------------
// sbcr_pkg: shared types and constants for the swept box collision block
// Word formats for the box and result channels, the carried context of the
// pipeline and the fixed widths of the time and division datapath.
// ---------------------------------------------------------------------------
package sbcr_pkg;

	// slab numerators and denominators
	localparam int NUM_W  = 26;
	localparam int DEN_W  = 24;
	localparam int PROD_W = NUM_W + DEN_W + 1;

	// contact time and its divider
	localparam int T_W        = 16;
	localparam int DIV_BITS   = 2;
	localparam int DIV_STAGES = T_W / DIV_BITS;
	localparam int NUM_STAGES = 4 + DIV_STAGES + 3;

	// normal codes, Q1.14
	localparam logic signed [15:0] NRM_ONE    = 16'sd16384;
	localparam logic signed [15:0] NRM_ONE_N  = -16'sd16384;
	localparam logic signed [15:0] NRM_DIAG   = 16'sd11585;
	localparam logic signed [15:0] NRM_DIAG_N = -16'sd11585;

	localparam logic signed [43:0] Q24_MAX = 44'sd8388607;
	localparam logic signed [43:0] Q24_MIN = -44'sd8388608;

	typedef struct packed {
		logic signed [23:0] moving_x;
		logic signed [23:0] moving_y;
		logic        [22:0] moving_w;
		logic        [22:0] moving_h;
		logic signed [23:0] move_dx;
		logic signed [23:0] move_dy;
		logic signed [23:0] target_x;
		logic signed [23:0] target_y;
		logic        [22:0] target_w;
		logic        [22:0] target_h;
	} box_t;

	typedef struct packed {
		logic               hit;
		logic signed [23:0] adjusted_dx;
		logic signed [23:0] adjusted_dy;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic        [15:0] contact_time;
		logic signed [23:0] contact_x;
		logic signed [23:0] contact_y;
	} res_t;

	typedef struct packed {
		logic               hit;
		logic signed [15:0] nrm_x;
		logic signed [15:0] nrm_y;
		logic signed [23:0] dx;
		logic signed [23:0] dy;
		logic signed [23:0] mx;
		logic signed [23:0] my;
		logic        [22:0] mw;
		logic        [22:0] mh;
	} ctx_t;

endpackage

// ----- src/swept_box_collision_resolve.sv -----
// ---------------------------------------------------------------------------
// swept_box_collision_resolve: swept box against box test with resolution
// Grows the target by the mover, runs a slab ray test from the mover's
// centre and reports contact time, normal, centre and corrected movement.
// ---------------------------------------------------------------------------
// Usage:
//   box channel (box_valid/box_ready/box) takes one mover/target pair per
//   word; res channel (res_valid/res_ready/res) returns one result word per
//   box word, in order.
//   A word passes from box acceptance to res_valid through fifteen register
//   stages: four of slab setup, cross-multiplied compares and hit decision,
//   eight of a radix-4 restoring divider for the Q0.16 contact time, and
//   three of contact and correction multiplies with saturation, the last
//   being the output register.
//   Throughput is one word per cycle while the receiver keeps res_ready high;
//   every stage holds its own valid bit. When the receiver stalls, stages fill
//   up behind the output register and box_ready drops only once the first stage is occupied
//   and cannot move; bubbles are squeezed out while stalled.
//   Reset clears all valid bits; no word is in flight afterwards.
//   A word without a hit returns zero normal, time and contact, and the
//   movement unchanged.
// ---------------------------------------------------------------------------
module swept_box_collision_resolve (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             box_valid,
	output logic             box_ready,
	input  sbcr_pkg::box_t   box,
	output logic             res_valid,
	input  logic             res_ready,
	output sbcr_pkg::res_t   res
);

	localparam int NS = sbcr_pkg::NUM_STAGES;
	localparam int DS = sbcr_pkg::DIV_STAGES;
	localparam int NW = sbcr_pkg::NUM_W;
	localparam int DW = sbcr_pkg::DEN_W;
	localparam int PW = sbcr_pkg::PROD_W;
	localparam int TW = sbcr_pkg::T_W;
	localparam int IX_DIV = 4;
	localparam int IX_S13 = 4 + DS;
	localparam int IX_S14 = IX_S13 + 1;
	localparam int IX_S15 = IX_S13 + 2;

	// compare two slab times, each a fraction or an infinity; returns {gt, lt}
	function automatic logic [1:0] cmp_time(
		input logic signed [NW-1:0] an,
		input logic                 az,
		input logic signed [NW-1:0] bn,
		input logic                 bz,
		input logic signed [PW-1:0] l,
		input logic signed [PW-1:0] r
	);
		logic gt;
		logic lt;
		if (az && bz) begin
			gt = !an[NW-1] && bn[NW-1];
			lt = an[NW-1] && !bn[NW-1];
		end else if (az) begin
			gt = !an[NW-1];
			lt = an[NW-1];
		end else if (bz) begin
			lt = !bn[NW-1];
			gt = bn[NW-1];
		end else begin
			gt = l > r;
			lt = l < r;
		end
		return {gt, lt};
	endfunction

	// clamp to the signed 24 bit range
	function automatic logic signed [23:0] sat24(input logic signed [43:0] v);
		logic signed [23:0] o;
		if (v > sbcr_pkg::Q24_MAX) begin
			o = 24'(sbcr_pkg::Q24_MAX);
		end else if (v < sbcr_pkg::Q24_MIN) begin
			o = 24'(sbcr_pkg::Q24_MIN);
		end else begin
			o = v[23:0];
		end
		return o;
	endfunction

	// ------------------------------------------------------------------
	// handshake: a stage moves when empty or when the next one moves
	// ------------------------------------------------------------------
	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;

	always_comb begin
		en[NS-1] = !vld_q[NS-1] || res_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign box_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= box_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// s1: raw slab numerators and movement magnitudes
	// ------------------------------------------------------------------
	logic signed [NW-1:0] xn_s1, xf_s1, yn_s1, yf_s1;
	logic        [DW-1:0] dxa_s1, dya_s1;
	sbcr_pkg::ctx_t       ctx_s1;
	sbcr_pkg::ctx_t       ctx_in;

	always_comb begin
		ctx_in       = '0;
		ctx_in.dx    = box.move_dx;
		ctx_in.dy    = box.move_dy;
		ctx_in.mx    = box.moving_x;
		ctx_in.my    = box.moving_y;
		ctx_in.mw    = box.moving_w;
		ctx_in.mh    = box.moving_h;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			xn_s1  <= NW'(box.target_x) - NW'(box.moving_x) - $signed(NW'(box.moving_w));
			xf_s1  <= NW'(box.target_x) + $signed(NW'(box.target_w)) - NW'(box.moving_x);
			yn_s1  <= NW'(box.target_y) - NW'(box.moving_y) - $signed(NW'(box.moving_h));
			yf_s1  <= NW'(box.target_y) + $signed(NW'(box.target_h)) - NW'(box.moving_y);
			dxa_s1 <= box.move_dx[23] ? DW'(-box.move_dx) : DW'(box.move_dx);
			dya_s1 <= box.move_dy[23] ? DW'(-box.move_dy) : DW'(box.move_dy);
			ctx_s1 <= ctx_in;
		end
	end

	// ------------------------------------------------------------------
	// s2: orient numerators along travel, swap into near/far, flag 0/0
	// ------------------------------------------------------------------
	logic signed [NW-1:0] xn_o, xf_o, yn_o, yf_o;
	logic signed [NW-1:0] xn_s2, xf_s2, yn_s2, yf_s2;
	logic        [DW-1:0] dxa_s2, dya_s2;
	logic                 dxz, dyz, bad;
	logic                 bad_s2;
	sbcr_pkg::ctx_t       ctx_s2;

	always_comb begin
		xn_o = ctx_s1.dx[23] ? -xn_s1 : xn_s1;
		xf_o = ctx_s1.dx[23] ? -xf_s1 : xf_s1;
		yn_o = ctx_s1.dy[23] ? -yn_s1 : yn_s1;
		yf_o = ctx_s1.dy[23] ? -yf_s1 : yf_s1;
		dxz  = (dxa_s1 == '0);
		dyz  = (dya_s1 == '0);
		bad  = (dxz && (xn_s1 == '0 || xf_s1 == '0)) ||
		       (dyz && (yn_s1 == '0 || yf_s1 == '0));
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			xn_s2  <= (xn_o > xf_o) ? xf_o : xn_o;
			xf_s2  <= (xn_o > xf_o) ? xn_o : xf_o;
			yn_s2  <= (yn_o > yf_o) ? yf_o : yn_o;
			yf_s2  <= (yn_o > yf_o) ? yn_o : yf_o;
			dxa_s2 <= dxa_s1;
			dya_s2 <= dya_s1;
			bad_s2 <= bad;
			ctx_s2 <= ctx_s1;
		end
	end

	// ------------------------------------------------------------------
	// s3: cross products for the fraction compares
	// ------------------------------------------------------------------
	logic signed [PW-1:0] p_nxdy_s3, p_fydx_s3, p_nydx_s3, p_fxdy_s3;
	logic signed [NW-1:0] xn_s3, xf_s3, yn_s3, yf_s3;
	logic        [DW-1:0] dxa_s3, dya_s3;
	logic                 bad_s3;
	sbcr_pkg::ctx_t       ctx_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			p_nxdy_s3 <= xn_s2 * $signed({1'b0, dya_s2});
			p_fydx_s3 <= yf_s2 * $signed({1'b0, dxa_s2});
			p_nydx_s3 <= yn_s2 * $signed({1'b0, dxa_s2});
			p_fxdy_s3 <= xf_s2 * $signed({1'b0, dya_s2});
			xn_s3     <= xn_s2;
			xf_s3     <= xf_s2;
			yn_s3     <= yn_s2;
			yf_s3     <= yf_s2;
			dxa_s3    <= dxa_s2;
			dya_s3    <= dya_s2;
			bad_s3    <= bad_s2;
			ctx_s3    <= ctx_s2;
		end
	end

	// ------------------------------------------------------------------
	// s4: rejection test, entry time pick, hit and normal
	// ------------------------------------------------------------------
	logic [1:0]           c_nxfy, c_nyfx, c_nxny;
	logic                 zx3, zy3, pass, diag, tz, tok, hit4;
	logic signed [NW-1:0] tn;
	logic        [DW-1:0] tden;
	sbcr_pkg::ctx_t       ctx4;
	logic        [DW-1:0] tnum_s4, tden_s4;
	sbcr_pkg::ctx_t       ctx_s4;

	always_comb begin
		zx3    = (dxa_s3 == '0);
		zy3    = (dya_s3 == '0);
		c_nxfy = cmp_time(xn_s3, zx3, yf_s3, zy3, p_nxdy_s3, p_fydx_s3);
		c_nyfx = cmp_time(yn_s3, zy3, xf_s3, zx3, p_nydx_s3, p_fxdy_s3);
		c_nxny = cmp_time(xn_s3, zx3, yn_s3, zy3, p_nxdy_s3, p_nydx_s3);
		pass   = c_nxfy[0] && c_nyfx[0];
		diag   = !c_nxny[1] && !c_nxny[0];
		tn     = c_nxny[0] ? yn_s3 : xn_s3;
		tz     = c_nxny[0] ? zy3 : zx3;
		tden   = c_nxny[0] ? dya_s3 : dxa_s3;
		tok    = !tz && !tn[NW-1] && (tn < $signed({2'b00, tden}));
		hit4   = !bad_s3 && pass && tok && (!diag || (!zx3 && !zy3));
		ctx4   = ctx_s3;
		ctx4.hit = hit4;
		// x normal on a later x entry or a diagonal corner, against travel
		if (c_nxny[1] || diag) begin
			if (diag) begin
				ctx4.nrm_x = ctx_s3.dx[23] ? sbcr_pkg::NRM_DIAG : sbcr_pkg::NRM_DIAG_N;
			end else begin
				ctx4.nrm_x = ctx_s3.dx[23] ? sbcr_pkg::NRM_ONE : sbcr_pkg::NRM_ONE_N;
			end
		end else begin
			ctx4.nrm_x = '0;
		end
		if (c_nxny[0] || diag) begin
			if (diag) begin
				ctx4.nrm_y = ctx_s3.dy[23] ? sbcr_pkg::NRM_DIAG : sbcr_pkg::NRM_DIAG_N;
			end else begin
				ctx4.nrm_y = ctx_s3.dy[23] ? sbcr_pkg::NRM_ONE : sbcr_pkg::NRM_ONE_N;
			end
		end else begin
			ctx4.nrm_y = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			tnum_s4 <= tn[DW-1:0];
			tden_s4 <= tden;
			ctx_s4  <= ctx4;
		end
	end

	// ------------------------------------------------------------------
	// divider stages: restoring division, DIV_BITS quotient bits each
	// ------------------------------------------------------------------
	logic [DW-1:0]  rem_sd [DS];
	logic [DW-1:0]  den_sd [DS];
	logic [TW-1:0]  quo_sd [DS];
	sbcr_pkg::ctx_t ctx_sd [DS];

	for (genvar g = 0; g < DS; g++) begin : g_div
		logic [DW-1:0]  r_in, d_in, r_nx;
		logic [TW-1:0]  q_in, q_nx;
		sbcr_pkg::ctx_t c_in;
		logic [DW:0]    r2;
		logic [DW+1:0]  diff;

		// take the decision stage or the previous divider stage
		if (g == 0) begin : g_head
			assign r_in = tnum_s4;
			assign d_in = tden_s4;
			assign q_in = '0;
			assign c_in = ctx_s4;
		end else begin : g_tail
			assign r_in = rem_sd[g-1];
			assign d_in = den_sd[g-1];
			assign q_in = quo_sd[g-1];
			assign c_in = ctx_sd[g-1];
		end

		always_comb begin
			r_nx = r_in;
			q_nx = q_in;
			r2   = '0;
			diff = '0;
			for (int b = 0; b < sbcr_pkg::DIV_BITS; b++) begin
				r2   = {r_nx, 1'b0};
				diff = {1'b0, r2} - {2'b00, d_in};
				if (!diff[DW+1]) begin
					r_nx = diff[DW-1:0];
					q_nx = {q_nx[TW-2:0], 1'b1};
				end else begin
					r_nx = r2[DW-1:0];
					q_nx = {q_nx[TW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[IX_DIV+g]) begin
				rem_sd[g] <= r_nx;
				den_sd[g] <= d_in;
				quo_sd[g] <= q_nx;
				ctx_sd[g] <= c_in;
			end
		end
	end

	// ------------------------------------------------------------------
	// s13: movement times contact time, speed times remaining time
	// ------------------------------------------------------------------
	logic [TW-1:0]        t16;
	logic [TW:0]          trem;
	logic [23:0]          adx, ady;
	logic signed [40:0]   cpx_s13, cpy_s13;
	logic        [40:0]   spx_s13, spy_s13;
	logic        [14:0]   mgx_s13, mgy_s13;
	logic [TW-1:0]        t16_s13;
	sbcr_pkg::ctx_t       ctx_s13;
	sbcr_pkg::ctx_t       cl;

	always_comb begin
		cl   = ctx_sd[DS-1];
		t16  = quo_sd[DS-1];
		trem = {1'b1, {TW{1'b0}}} - {1'b0, t16};
		adx  = cl.dx[23] ? 24'(-cl.dx) : 24'(cl.dx);
		ady  = cl.dy[23] ? 24'(-cl.dy) : 24'(cl.dy);
	end

	always_ff @(posedge clk) begin
		if (en[IX_S13]) begin
			cpx_s13 <= cl.dx * $signed({1'b0, t16});
			cpy_s13 <= cl.dy * $signed({1'b0, t16});
			spx_s13 <= 41'(adx) * 41'(trem);
			spy_s13 <= 41'(ady) * 41'(trem);
			mgx_s13 <= cl.nrm_x[15] ? 15'(-cl.nrm_x) : cl.nrm_x[14:0];
			mgy_s13 <= cl.nrm_y[15] ? 15'(-cl.nrm_y) : cl.nrm_y[14:0];
			t16_s13 <= t16;
			ctx_s13 <= cl;
		end
	end

	// ------------------------------------------------------------------
	// s14: contact centre, normal magnitude times swept remainder
	// ------------------------------------------------------------------
	logic signed [43:0]   ctr_x, ctr_y;
	logic signed [23:0]   cx_s14, cy_s14;
	logic        [55:0]   mx_s14, my_s14;
	logic [TW-1:0]        t16_s14;
	sbcr_pkg::ctx_t       ctx_s14;

	always_comb begin
		ctr_x = ((44'(ctx_s13.mx) <<< 17) + $signed(44'(ctx_s13.mw) << 16) +
		         (44'(cpx_s13) <<< 1)) >>> 17;
		ctr_y = ((44'(ctx_s13.my) <<< 17) + $signed(44'(ctx_s13.mh) << 16) +
		         (44'(cpy_s13) <<< 1)) >>> 17;
	end

	always_ff @(posedge clk) begin
		if (en[IX_S14]) begin
			cx_s14  <= sat24(ctr_x);
			cy_s14  <= sat24(ctr_y);
			mx_s14  <= 56'(spx_s13) * 56'(mgx_s13);
			my_s14  <= 56'(spy_s13) * 56'(mgy_s13);
			t16_s14 <= t16_s13;
			ctx_s14 <= ctx_s13;
		end
	end

	// ------------------------------------------------------------------
	// s15: corrected movement, drop fields of a miss, output register
	// ------------------------------------------------------------------
	logic signed [56:0] trm_x, trm_y;
	logic signed [43:0] adj_x, adj_y;
	sbcr_pkg::res_t     res_nx;
	sbcr_pkg::res_t     res_s15;

	always_comb begin
		trm_x = ctx_s14.nrm_x[15] ? -$signed({1'b0, mx_s14}) : $signed({1'b0, mx_s14});
		trm_y = ctx_s14.nrm_y[15] ? -$signed({1'b0, my_s14}) : $signed({1'b0, my_s14});
		adj_x = 44'(ctx_s14.dx) + 44'(trm_x >>> 30);
		adj_y = 44'(ctx_s14.dy) + 44'(trm_y >>> 30);
		res_nx.hit = ctx_s14.hit;
		if (ctx_s14.hit) begin
			res_nx.adjusted_dx  = sat24(adj_x);
			res_nx.adjusted_dy  = sat24(adj_y);
			res_nx.normal_x     = ctx_s14.nrm_x;
			res_nx.normal_y     = ctx_s14.nrm_y;
			res_nx.contact_time = t16_s14;
			res_nx.contact_x    = cx_s14;
			res_nx.contact_y    = cy_s14;
		end else begin
			res_nx.adjusted_dx  = ctx_s14.dx;
			res_nx.adjusted_dy  = ctx_s14.dy;
			res_nx.normal_x     = '0;
			res_nx.normal_y     = '0;
			res_nx.contact_time = '0;
			res_nx.contact_x    = '0;
			res_nx.contact_y    = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[IX_S15]) begin
			res_s15 <= res_nx;
		end
	end

	assign res_valid = vld_q[NS-1];
	assign res       = res_s15;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	a_hit_has_normal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.hit |-> (res.normal_x != '0 || res.normal_y != '0))
		else $error("hit word without a normal");

	a_miss_is_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.hit |->
		(res.normal_x == '0 && res.normal_y == '0 && res.contact_time == '0))
		else $error("miss word carries contact fields");

	a_diag_normal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.normal_x != '0 && res.normal_y != '0 |->
		((res.normal_x == sbcr_pkg::NRM_DIAG || res.normal_x == sbcr_pkg::NRM_DIAG_N) &&
		 (res.normal_y == sbcr_pkg::NRM_DIAG || res.normal_y == sbcr_pkg::NRM_DIAG_N)))
		else $error("two-axis normal is not diagonal");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> box_ready)
		else $error("box_ready low with an empty output register");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for swept_box_collision_resolve
// Drives mover/target pairs through the box channel with random idling and
// back pressure, predicts each result word with an exact fraction slab test
// and compares every returned word field by field, in order.
// ---------------------------------------------------------------------------
module tb;

	// exact slab time: numerator over positive denominator, den 0 = infinite
	typedef struct {
		longint num;
		longint den;
	} slab_time_t;

	// scoreboard of predicted collision results
	class collision_board;
		sbcr_pkg::res_t pending[$];
		int             errors;

		function longint floor_sh(longint v, int k);
			longint m;
			m = (longint'(1) << k) - 1;
			if (v >= 0)
				return v >>> k;
			return -((-v + m) >>> k);
		endfunction

		function longint clamp24(longint v);
			if (v > 8388607)
				return 8388607;
			if (v < -8388608)
				return -8388608;
			return v;
		endfunction

		function bit build_time(longint n, longint d, output slab_time_t t);
			if (d == 0) begin
				if (n == 0)
					return 0;
				t.num = n > 0 ? 1 : -1;
				t.den = 0;
			end else if (d < 0) begin
				t.num = -n;
				t.den = -d;
			end else begin
				t.num = n;
				t.den = d;
			end
			return 1;
		endfunction

		function int order(slab_time_t a, slab_time_t b);
			longint l, r;
			if (a.den == 0 && b.den == 0)
				return (a.num > b.num) - (a.num < b.num);
			if (a.den == 0)
				return a.num > 0 ? 1 : -1;
			if (b.den == 0)
				return b.num > 0 ? -1 : 1;
			l = a.num * b.den;
			r = b.num * a.den;
			return (l > r) - (l < r);
		endfunction

		function sbcr_pkg::res_t resolve(sbcr_pkg::box_t b);
			sbcr_pkg::res_t r;
			longint mx, my, mw, mh, dx, dy, tx, ty, tw, th;
			longint nrx, nry, t16, rem, sx, sy;
			slab_time_t nx, fx, ny, fy, t, tmp, zero_t, one_t;
			bit ok, hit;
			int c;
			mx = longint'(b.moving_x); my = longint'(b.moving_y);
			mw = longint'(b.moving_w); mh = longint'(b.moving_h);
			dx = longint'(b.move_dx); dy = longint'(b.move_dy);
			tx = longint'(b.target_x); ty = longint'(b.target_y);
			tw = longint'(b.target_w); th = longint'(b.target_h);
			zero_t.num = 0; zero_t.den = 1; one_t.num = 1; one_t.den = 1;
			nrx = 0; nry = 0; hit = 0;
			r = '0;
			r.adjusted_dx = b.move_dx;
			r.adjusted_dy = b.move_dy;
			ok = build_time(tx - mx - mw, dx, nx);
			if (ok) ok = build_time(tx + tw - mx, dx, fx);
			if (ok) ok = build_time(ty - my - mh, dy, ny);
			if (ok) ok = build_time(ty + th - my, dy, fy);
			if (!ok)
				return r;
			if (order(nx, fx) > 0) begin tmp = nx; nx = fx; fx = tmp; end
			if (order(ny, fy) > 0) begin tmp = ny; ny = fy; fy = tmp; end
			if (!(order(nx, fy) < 0 && order(ny, fx) < 0))
				return r;
			t = order(nx, ny) >= 0 ? nx : ny;
			if (!(order(t, zero_t) >= 0 && order(t, one_t) < 0))
				return r;
			c = order(nx, ny);
			hit = 1;
			if (c < 0) begin
				nry = dy < 0 ? 16384 : -16384;
			end else if (c > 0) begin
				nrx = dx < 0 ? 16384 : -16384;
			end else if (dx != 0 && dy != 0) begin
				// diagonal corner: repaired normal against travel
				nrx = dx < 0 ? 11585 : -11585;
				nry = dy < 0 ? 11585 : -11585;
			end else begin
				hit = 0;
			end
			if (!hit)
				return r;
			t16 = (t.num << 16) / t.den;
			if (t16 > 65535)
				t16 = 65535;
			rem = 65536 - t16;
			sx = dx < 0 ? -dx : dx;
			sy = dy < 0 ? -dy : dy;
			r.hit = 1'b1;
			r.normal_x = 16'(nrx);
			r.normal_y = 16'(nry);
			r.contact_time = 16'(t16);
			r.contact_x = 24'(clamp24(floor_sh(mx * 131072 + mw * 65536 + 2 * dx * t16, 17)));
			r.contact_y = 24'(clamp24(floor_sh(my * 131072 + mh * 65536 + 2 * dy * t16, 17)));
			r.adjusted_dx = 24'(clamp24(dx + floor_sh(nrx * sx * rem, 30)));
			r.adjusted_dy = 24'(clamp24(dy + floor_sh(nry * sy * rem, 30)));
			return r;
		endfunction

		function void note_box(sbcr_pkg::box_t b);
			pending.push_back(resolve(b));
		endfunction

		function void check_res(sbcr_pkg::res_t got);
			sbcr_pkg::res_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.hit !== want.hit) begin
				$display("%0t: hit exp %0d got %0d", $time, want.hit, got.hit);
				errors++;
			end
			if (got.adjusted_dx !== want.adjusted_dx) begin
				$display("%0t: adjusted_dx exp %0d got %0d", $time,
					want.adjusted_dx, got.adjusted_dx);
				errors++;
			end
			if (got.adjusted_dy !== want.adjusted_dy) begin
				$display("%0t: adjusted_dy exp %0d got %0d", $time,
					want.adjusted_dy, got.adjusted_dy);
				errors++;
			end
			if (got.normal_x !== want.normal_x) begin
				$display("%0t: normal_x exp %0d got %0d", $time, want.normal_x, got.normal_x);
				errors++;
			end
			if (got.normal_y !== want.normal_y) begin
				$display("%0t: normal_y exp %0d got %0d", $time, want.normal_y, got.normal_y);
				errors++;
			end
			if (got.contact_time !== want.contact_time) begin
				$display("%0t: contact_time exp %0d got %0d", $time,
					want.contact_time, got.contact_time);
				errors++;
			end
			if (got.contact_x !== want.contact_x) begin
				$display("%0t: contact_x exp %0d got %0d", $time, want.contact_x, got.contact_x);
				errors++;
			end
			if (got.contact_y !== want.contact_y) begin
				$display("%0t: contact_y exp %0d got %0d", $time, want.contact_y, got.contact_y);
				errors++;
			end
		endfunction
	endclass

	localparam int WATCHDOG = 20000;

	logic           clk;
	logic           arst_n;
	logic           box_valid;
	logic           box_ready;
	sbcr_pkg::box_t box;
	logic           res_valid;
	logic           res_ready;
	sbcr_pkg::res_t res;

	collision_board board;
	bit             calm;      // no idling in the final stretch
	bit             hold_res;  // long receiver hold-off
	int             quiet;
	int             stall_n;   // remaining cycles of a receiver idle burst

	swept_box_collision_resolve u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.box_valid (box_valid),
		.box_ready (box_ready),
		.box       (box),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// send one word and wait for its acceptance; valid stays up between words unless a random idle gap is drawn
	task automatic send_box(sbcr_pkg::box_t b);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 9);
			box_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		box_valid <= 1'b1;
		box       <= b;
		do @(posedge clk); while (!box_ready);
		board.note_box(b);
	endtask

	task automatic send_idle();
		box_valid <= 1'b0;
	endtask

	function automatic logic signed [23:0] rnd24();
		case ($urandom_range(0, 3))
			0: return 24'($urandom);
			1: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
			default: return 24'($signed($urandom_range(0, 8192)) - 4096);
		endcase
	endfunction

	function automatic logic [22:0] rnd23();
		case ($urandom_range(0, 3))
			0: return 23'($urandom);
			1: return $urandom_range(0, 1) ? 23'h7fffff : 23'h0;
			default: return 23'($urandom_range(0, 2048));
		endcase
	endfunction

	// mostly near pairs aimed at each other, some wide noise
	function automatic sbcr_pkg::box_t random_pair();
		sbcr_pkg::box_t b;
		b.moving_x = rnd24();
		b.moving_y = rnd24();
		b.moving_w = rnd23();
		b.moving_h = rnd23();
		b.move_dx  = rnd24();
		b.move_dy  = rnd24();
		b.target_x = rnd24();
		b.target_y = rnd24();
		b.target_w = rnd23();
		b.target_h = rnd23();
		if ($urandom_range(0, 3) != 0) begin
			b.moving_x = 24'($signed($urandom_range(0, 4000)) - 2000);
			b.moving_y = 24'($signed($urandom_range(0, 4000)) - 2000);
			b.moving_w = 23'($urandom_range(0, 800));
			b.moving_h = 23'($urandom_range(0, 800));
			b.target_w = 23'($urandom_range(0, 800));
			b.target_h = 23'($urandom_range(0, 800));
			b.target_x = 24'($signed($urandom_range(0, 4000)) - 2000);
			b.target_y = 24'($signed($urandom_range(0, 4000)) - 2000);
			b.move_dx  = 24'((b.target_x - b.moving_x) * $signed($urandom_range(0, 3))
				+ $signed($urandom_range(0, 400)) - 200);
			b.move_dy  = 24'((b.target_y - b.moving_y) * $signed($urandom_range(0, 3))
				+ $signed($urandom_range(0, 400)) - 200);
			if ($urandom_range(0, 7) == 0) b.move_dx = '0;
			if ($urandom_range(0, 7) == 0) b.move_dy = '0;
		end
		return b;
	endfunction

	function automatic sbcr_pkg::box_t make_box(int mx, int my, int mw, int mh, int dx,
			int dy, int tx, int ty, int tw, int th);
		sbcr_pkg::box_t b;
		b.moving_x = 24'(mx); b.moving_y = 24'(my);
		b.moving_w = 23'(mw); b.moving_h = 23'(mh);
		b.move_dx = 24'(dx); b.move_dy = 24'(dy);
		b.target_x = 24'(tx); b.target_y = 24'(ty);
		b.target_w = 23'(tw); b.target_h = 23'(th);
		return b;
	endfunction

	// receiver: random idle bursts, one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			stall_n   <= 0;
		end else if (hold_res) begin
			res_ready <= 1'b0;
		end else if (calm) begin
			res_ready <= 1'b1;
		end else if (stall_n > 0) begin
			res_ready <= 1'b0;
			stall_n   <= stall_n - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			res_ready <= 1'b0;
			stall_n   <= $urandom_range(0, 8);
		end else begin
			res_ready <= 1'b1;
		end
	end

	// check every accepted result word
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			board.check_res(res);
	end

	// watchdog on cycles without any acceptance
	always @(posedge clk) begin
		if ((box_valid && box_ready) || (res_valid && res_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		hold_res = 1'b0;
		wait (arst_n);
		repeat (400) @(posedge clk);
		hold_res <= 1'b1;
		repeat (120) @(posedge clk);
		hold_res <= 1'b0;
	end

	initial begin
		board     = new();
		calm      = 1'b0;
		quiet     = 0;
		arst_n    = 1'b0;
		box_valid = 1'b0;
		box       = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: axis hits in each direction, diagonal corner, edge cases
		send_box(make_box(0, 0, 256, 256, 1024, 0, 512, 0, 256, 256));
		send_box(make_box(1024, 0, 256, 256, -1024, 0, 0, 0, 256, 256));
		send_box(make_box(0, 0, 256, 256, 0, 1024, 0, 512, 256, 256));
		send_box(make_box(0, 1024, 256, 256, 0, -1024, 0, 0, 256, 256));
		send_box(make_box(0, 0, 256, 256, 1024, 1024, 512, 512, 256, 256));
		send_box(make_box(1024, 1024, 256, 256, -1024, -1024, 0, 0, 256, 256));
		send_box(make_box(0, 0, 256, 256, 1024, -1024, 512, -512, 256, 256));
		// zero x movement with origin on an x slab edge
		send_box(make_box(0, 0, 256, 256, 0, 1024, 256, 512, 256, 256));
		// exact corner while moving along one axis
		send_box(make_box(0, 0, 256, 256, 1024, 0, 512, 256, 256, 256));
		// touching at start, too far, miss
		send_box(make_box(0, 0, 256, 256, 512, 0, 256, 0, 256, 256));
		send_box(make_box(0, 0, 256, 256, 100, 0, 1024, 0, 256, 256));
		send_box(make_box(0, 0, 256, 256, -1024, 0, 512, 0, 256, 256));
		send_box(make_box(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// extremes for saturation
		send_box(make_box(8388607, 8388607, 8388607, 8388607, -8388608, -8388608,
			-8388608, -8388608, 8388607, 8388607));
		send_box(make_box(-8388608, -8388608, 8388607, 8388607, 8388607, 8388607,
			8388607, 8388607, 8388607, 8388607));
		send_box(make_box(-8388608, 0, 8388607, 0, 8388607, 0, 0, -10, 8388607, 20));
		send_box(make_box(8388607, 0, 0, 0, -8388608, 1, -8388608, 0, 0, 8388607));
		send_box(make_box(-1, -1, 1, 1, 8388607, -8388608, 5, -3, 1, 1));
		send_box(make_box(100, 100, 8388607, 8388607, 1, 1, -8388608, -8388608,
			8388607, 8388607));

		// random body
		for (int i = 0; i < 1500; i++) begin
			send_box(random_pair());
			// sender pause until everything drained
			if (i == 700) begin
				send_idle();
				while (board.pending.size() != 0) @(posedge clk);
			end
		end
		calm = 1'b1;
		for (int i = 0; i < 100; i++)
			send_box(random_pair());
		send_idle();

		while (board.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (board.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
